[hdl/egsm_pkg.sv]
// ============================================================================
// egsm_pkg
// Shared types, constants and tables for the elevation grid slope map.
// ============================================================================
package egsm_pkg;

    localparam int MAP_CELLS_DEFAULT = 128;

    // configuration reset values
    localparam logic [9:0]  CELL_SIZE_RESET  = 10'd100;
    localparam logic [13:0] MAX_SLOPE_RESET  = 14'd2500;
    localparam logic [13:0] OBST_SLOPE_RESET = 14'd3500;
    localparam logic [12:0] VEH_HEIGHT_RESET = 13'd500;

    typedef enum logic [1:0] {
        CFG_CELL_SIZE  = 2'd0,
        CFG_MAX_SLOPE  = 2'd1,
        CFG_OBST_SLOPE = 2'd2,
        CFG_VEH_HEIGHT = 2'd3
    } cfg_idx_t;

    // shared divider
    localparam int DIV_NW = 28;
    localparam int DIV_DW = 16;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

    // vectoring cordic, angles in 1/256 centidegree
    localparam int CORD_XW    = 30;
    localparam int CORD_AW    = 24;
    localparam int CORD_STEPS = 16;
    localparam int SLOPE_W    = 14;
    localparam logic [15:0] SLOPE_MAX = 16'd9000;

    typedef struct packed {
        logic                      start;
        logic signed [CORD_XW-1:0] x0;
        logic signed [CORD_XW-1:0] y0;
    } cord_req_t;

    typedef struct packed {
        logic               done;
        logic [SLOPE_W-1:0] cdeg;
    } cord_rsp_t;

    // dz is scaled by the same factor as an edge run
    localparam logic [9:0]  RISE_SCALE = 10'd1000;
    localparam logic [10:0] RUN_EDGE   = 11'd1000;
    localparam logic [10:0] RUN_DIAG   = 11'd1414;

    // neighbor walk over a 3x3 window, row major
    localparam logic [3:0] NB_CENTER = 4'd4;
    localparam logic [3:0] NB_COUNT  = 4'd9;

    typedef struct packed {
        logic signed [1:0] dr;
        logic signed [1:0] dc;
    } nb_off_t;

    function automatic nb_off_t nb_offset(input logic [3:0] nb);
        nb_off_t o;
        case (nb)
            4'd0:    o = '{dr: -2'sd1, dc: -2'sd1};
            4'd1:    o = '{dr: -2'sd1, dc:  2'sd0};
            4'd2:    o = '{dr: -2'sd1, dc:  2'sd1};
            4'd3:    o = '{dr:  2'sd0, dc: -2'sd1};
            4'd5:    o = '{dr:  2'sd0, dc:  2'sd1};
            4'd6:    o = '{dr:  2'sd1, dc: -2'sd1};
            4'd7:    o = '{dr:  2'sd1, dc:  2'sd0};
            4'd8:    o = '{dr:  2'sd1, dc:  2'sd1};
            default: o = '{dr:  2'sd0, dc:  2'sd0};
        endcase
        return o;
    endfunction

    function automatic logic [20:0] atan_step(input logic [3:0] i);
        logic [20:0] a;
        case (i)
            4'd0:    a = 21'd1152000;
            4'd1:    a = 21'd680065;
            4'd2:    a = 21'd359328;
            4'd3:    a = 21'd182400;
            4'd4:    a = 21'd91554;
            4'd5:    a = 21'd45822;
            4'd6:    a = 21'd22916;
            4'd7:    a = 21'd11459;
            4'd8:    a = 21'd5730;
            4'd9:    a = 21'd2865;
            4'd10:   a = 21'd1432;
            4'd11:   a = 21'd716;
            4'd12:   a = 21'd358;
            4'd13:   a = 21'd179;
            4'd14:   a = 21'd90;
            default: a = 21'd45;
        endcase
        return a;
    endfunction

endpackage

[hdl/egsm_ram.sv]
// ============================================================================
// egsm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module egsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[hdl/egsm_div.sv]
// ============================================================================
// egsm_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
module egsm_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  egsm_pkg::div_req_t  req,
    output egsm_pkg::div_rsp_t  rsp
);
    import egsm_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   trial;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DIV_DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            if (cnt_reg == CW'(DIV_NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule

[hdl/egsm_cordic.sv]
// ============================================================================
// egsm_cordic
// Vectoring CORDIC arctangent, one micro-rotation per cycle.
// ============================================================================
module egsm_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  egsm_pkg::cord_req_t req,
    output egsm_pkg::cord_rsp_t rsp
);
    import egsm_pkg::*;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [3:0]                i_reg, i_next;
    logic signed [CORD_XW-1:0] x_reg, x_next;
    logic signed [CORD_XW-1:0] y_reg, y_next;
    logic signed [CORD_AW-1:0] ang_reg, ang_next;
    logic signed [CORD_XW-1:0] xs, ys;
    logic signed [CORD_AW-1:0] at;
    logic [CORD_AW-1:0]        rnd;
    logic [15:0]               cd;

    // shift of a signed value is a floor division by 2^i
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = $signed(CORD_AW'(atan_step(i_reg)));

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;
        if (req.start) begin
            busy_next = 1'b1;
            i_next    = '0;
            x_next    = req.x0;
            y_next    = req.y0;
            ang_next  = '0;
        end else if (busy_reg) begin
            if (!y_reg[CORD_XW-1]) begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                ang_next = ang_reg + at;
            end else begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                ang_next = ang_reg - at;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == 4'(CORD_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        i_reg   <= i_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    // round half up to centidegrees, clamp to 0..9000
    assign rnd = CORD_AW'(ang_reg) + CORD_AW'(128);
    assign cd  = rnd[23:8];

    always_comb begin
        rsp.done = done_reg;
        if (ang_reg[CORD_AW-1]) begin
            rsp.cdeg = '0;
        end else if (cd > SLOPE_MAX) begin
            rsp.cdeg = SLOPE_W'(SLOPE_MAX);
        end else begin
            rsp.cdeg = cd[SLOPE_W-1:0];
        end
    end
endmodule

[hdl/elevation_grid_slope_map_core.sv]
// ============================================================================
// elevation_grid_slope_map_core
// Running-mean elevation grid with neighbor slope and intensity query.
// ============================================================================
//  channel   signals                                   direction
//  cfg       cfg_wr_en, cfg_index, cfg_wdata           in, write only
//  s_        s_valid/s_ready, action, point, query     in
//  m_        m_valid/m_ready, accepted, cell, slope, intensity  out
//
//  A point item uses three divisions on the shared divider: two place it in
//  a cell and a third forms the mean step. A query reads its cell, then for
//  each in-map neighbor a RAM read and a dz check, and a CORDIC run unless
//  the neighbor is flat; then one division for intensity, unless the slope
//  reaches the obstacle limit. After reset all MAP_CELLS*MAP_CELLS cells of
//  the grid RAM are swept to zero, with s_ready low. A waiting result in the
//  output register holds the next result back, not the next item.
// ============================================================================
module elevation_grid_slope_map_core #(
    parameter int MAP_CELLS = egsm_pkg::MAP_CELLS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [13:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [15:0] s_point_x_mm,
    input  logic signed [15:0] s_point_y_mm,
    input  logic signed [15:0] s_point_z_mm,
    input  logic [6:0]         s_query_row,
    input  logic [6:0]         s_query_col,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic signed [15:0] m_cell_elevation_mm,
    output logic [15:0]        m_cell_hits,
    output logic [13:0]        m_slope_cdeg,
    output logic [12:0]        m_intensity_mm
);
    import egsm_pkg::*;

    localparam int DEPTH = MAP_CELLS * MAP_CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAP_CELLS);
    localparam int RSW   = RW + 2;
    localparam int QW    = (RW + 1 > 7) ? RW + 1 : 7;
    localparam logic signed [RSW-1:0] MC_S = RSW'(MAP_CELLS);

    typedef enum logic [15:0] {
        S_CLEAR    = 16'b0000_0000_0000_0001,
        S_IDLE     = 16'b0000_0000_0000_0010,
        S_PT_CHK   = 16'b0000_0000_0000_0100,
        S_PT_DROW  = 16'b0000_0000_0000_1000,
        S_PT_DCOL  = 16'b0000_0000_0001_0000,
        S_PT_RD    = 16'b0000_0000_0010_0000,
        S_PT_UPD   = 16'b0000_0000_0100_0000,
        S_PT_DMEAN = 16'b0000_0000_1000_0000,
        S_Q_RDC    = 16'b0000_0001_0000_0000,
        S_Q_CEN    = 16'b0000_0010_0000_0000,
        S_Q_NB     = 16'b0000_0100_0000_0000,
        S_Q_NRD    = 16'b0000_1000_0000_0000,
        S_Q_CORD   = 16'b0001_0000_0000_0000,
        S_Q_IMUL   = 16'b0010_0000_0000_0000,
        S_Q_IDIV   = 16'b0100_0000_0000_0000,
        S_DONE     = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [9:0]  cell_cfg_reg;
    logic [13:0] max_cfg_reg;
    logic [13:0] obst_cfg_reg;
    logic [12:0] height_cfg_reg;

    // item context
    logic [AW-1:0]      clr_reg, clr_next;
    logic [9:0]         cell_reg, cell_next;
    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] y_reg, y_next;
    logic signed [15:0] z_reg, z_next;
    logic [21:0]        uy_reg, uy_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [RW-1:0]      col_reg, col_next;
    logic signed [15:0] mean_reg, mean_next;
    logic [15:0]        hits_reg, hits_next;
    logic               neg_reg, neg_next;
    logic [3:0]         nb_reg, nb_next;
    logic [13:0]        best_reg, best_next;

    // result staging and output register
    logic               res_acc_reg, res_acc_next;
    logic signed [15:0] res_elev_reg, res_elev_next;
    logic [15:0]        res_hits_reg, res_hits_next;
    logic [13:0]        res_slope_reg, res_slope_next;
    logic [12:0]        res_int_reg, res_int_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_acc_reg;
    logic signed [15:0] m_elev_reg;
    logic [15:0]        m_hits_reg;
    logic [13:0]        m_slope_reg;
    logic [12:0]        m_int_reg;
    logic               out_load;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    cord_req_t cord_req;
    cord_rsp_t cord_rsp;

    // combinational helpers
    logic [9:0]          cell_eff;
    logic [QW-1:0]       q_row, q_col;
    logic [20:0]         span;
    logic signed [22:0]  ux_s, uy_s;
    logic                pt_out;
    logic [AW-1:0]       cell_addr, nb_addr;
    nb_off_t             nb_off;
    logic signed [RSW-1:0] nr_s, nc_s;
    logic                nb_in;
    logic [15:0]         hits_inc;
    logic signed [16:0]  diff;
    logic [16:0]         diff_mag;
    logic [16:0]         qmag;
    logic [16:0]         qsgn;
    logic signed [16:0]  dz_s;
    logic [16:0]         dz;
    logic [26:0]         rise;
    logic [20:0]         run;
    logic [14:0]         isum;

    assign cell_eff = (cell_cfg_reg == 10'd0) ? 10'd1 : cell_cfg_reg;
    assign q_row    = QW'(s_query_row);
    assign q_col    = QW'(s_query_col);

    // map spans -L/2 < x <= L/2; work in doubled units to stay integral
    assign span   = 21'(MAP_CELLS) * 21'(cell_reg);
    assign ux_s   = $signed({2'b00, span}) - $signed({{6{x_reg[15]}}, x_reg, 1'b0});
    assign uy_s   = $signed({2'b00, span}) - $signed({{6{y_reg[15]}}, y_reg, 1'b0});
    assign pt_out = ux_s[22] || uy_s[22] ||
                    (ux_s[21:0] >= {span, 1'b0}) || (uy_s[21:0] >= {span, 1'b0});

    assign cell_addr = AW'(row_reg) * AW'(MAP_CELLS) + AW'(col_reg);

    assign nb_off  = nb_offset(nb_reg);
    assign nr_s    = $signed({2'b00, row_reg}) + RSW'(nb_off.dr);
    assign nc_s    = $signed({2'b00, col_reg}) + RSW'(nb_off.dc);
    assign nb_in   = !nr_s[RSW-1] && !nc_s[RSW-1] && (nr_s < MC_S) && (nc_s < MC_S);
    assign nb_addr = AW'(nr_s[RW-1:0]) * AW'(MAP_CELLS) + AW'(nc_s[RW-1:0]);

    assign hits_inc = (ram_rdata[31:16] == 16'hFFFF) ? 16'hFFFF : ram_rdata[31:16] + 16'd1;
    assign diff     = 17'(z_reg) - 17'($signed(ram_rdata[15:0]));
    assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
    assign qmag     = div_rsp.quot[16:0];
    assign qsgn     = neg_reg ? 17'(-qmag) : qmag;

    assign dz_s = 17'(mean_reg) - 17'($signed(ram_rdata[15:0]));
    assign dz   = dz_s[16] ? 17'(-dz_s) : 17'(dz_s);
    assign rise = 27'(dz) * 27'(RISE_SCALE);
    assign run  = 21'(cell_reg) *
                  21'(((nb_off.dr != 2'sd0) && (nb_off.dc != 2'sd0)) ? RUN_DIAG : RUN_EDGE);

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cell_next      = cell_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        uy_next        = uy_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        mean_next      = mean_reg;
        hits_next      = hits_reg;
        neg_next       = neg_reg;
        nb_next        = nb_reg;
        best_next      = best_reg;
        res_acc_next   = res_acc_reg;
        res_elev_next  = res_elev_reg;
        res_hits_next  = res_hits_reg;
        res_slope_next = res_slope_reg;
        res_int_next   = res_int_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cell_addr;
        ram_wdata      = '0;
        ram_raddr      = cell_addr;
        div_req        = '0;
        cord_req       = '0;
        isum           = '0;

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cell_next      = cell_eff;
                    x_next         = s_point_x_mm;
                    y_next         = s_point_y_mm;
                    z_next         = s_point_z_mm;
                    res_acc_next   = 1'b0;
                    res_elev_next  = '0;
                    res_hits_next  = '0;
                    res_slope_next = '0;
                    res_int_next   = '0;
                    if (!s_action) begin
                        state_next = S_PT_CHK;
                    end else if (q_row < QW'(MAP_CELLS) && q_col < QW'(MAP_CELLS)) begin
                        row_next   = q_row[RW-1:0];
                        col_next   = q_col[RW-1:0];
                        state_next = S_Q_RDC;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PT_CHK: begin
                if (pt_out) begin
                    state_next = S_DONE;
                end else begin
                    uy_next       = uy_s[21:0];
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NW'(ux_s[21:0]);
                    div_req.den   = DIV_DW'({cell_reg, 1'b0});
                    state_next    = S_PT_DROW;
                end
            end
            S_PT_DROW: begin
                if (div_rsp.done) begin
                    row_next      = div_rsp.quot[RW-1:0];
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NW'(uy_reg);
                    div_req.den   = DIV_DW'({cell_reg, 1'b0});
                    state_next    = S_PT_DCOL;
                end
            end
            S_PT_DCOL: begin
                if (div_rsp.done) begin
                    col_next   = div_rsp.quot[RW-1:0];
                    state_next = S_PT_RD;
                end
            end
            S_PT_RD: begin
                state_next = S_PT_UPD;
            end
            S_PT_UPD: begin
                mean_next     = $signed(ram_rdata[15:0]);
                hits_next     = hits_inc;
                neg_next      = diff[16];
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(diff_mag);
                div_req.den   = hits_inc;
                state_next    = S_PT_DMEAN;
            end
            S_PT_DMEAN: begin
                if (div_rsp.done) begin
                    ram_we       = 1'b1;
                    ram_wdata    = {hits_reg, 16'(mean_reg + $signed(qsgn[15:0]))};
                    res_acc_next = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_Q_RDC: begin
                state_next = S_Q_CEN;
            end
            S_Q_CEN: begin
                mean_next  = $signed(ram_rdata[15:0]);
                hits_next  = ram_rdata[31:16];
                nb_next    = '0;
                best_next  = '0;
                state_next = S_Q_NB;
            end
            S_Q_NB: begin
                ram_raddr = nb_addr;
                if (nb_reg == NB_COUNT) begin
                    state_next = S_Q_IMUL;
                end else if (nb_reg == NB_CENTER || !nb_in) begin
                    nb_next = nb_reg + 1'b1;
                end else begin
                    state_next = S_Q_NRD;
                end
            end
            S_Q_NRD: begin
                // flat neighbor: angle is zero and cannot raise the maximum
                if (dz == 17'd0) begin
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_Q_NB;
                end else begin
                    cord_req.start = 1'b1;
                    cord_req.x0    = $signed(CORD_XW'(run));
                    cord_req.y0    = $signed(CORD_XW'(rise));
                    state_next     = S_Q_CORD;
                end
            end
            S_Q_CORD: begin
                if (cord_rsp.done) begin
                    if (cord_rsp.cdeg > best_reg) begin
                        best_next = cord_rsp.cdeg;
                    end
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_Q_NB;
                end
            end
            S_Q_IMUL: begin
                res_acc_next   = 1'b1;
                res_elev_next  = mean_reg;
                res_hits_next  = hits_reg;
                res_slope_next = best_reg;
                if (best_reg >= obst_cfg_reg) begin
                    res_int_next = height_cfg_reg;
                    state_next   = S_DONE;
                end else begin
                    if (best_reg >= max_cfg_reg) begin
                        isum        = 15'(obst_cfg_reg - max_cfg_reg) +
                                      15'(best_reg - max_cfg_reg);
                        div_req.den = DIV_DW'({obst_cfg_reg - max_cfg_reg, 1'b0});
                    end else begin
                        isum        = 15'(best_reg);
                        div_req.den = DIV_DW'({max_cfg_reg, 1'b0});
                    end
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NW'(height_cfg_reg) * DIV_NW'(isum);
                    state_next    = S_Q_IDIV;
                end
            end
            S_Q_IDIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot > DIV_NW'(height_cfg_reg)) begin
                        res_int_next = height_cfg_reg;
                    end else begin
                        res_int_next = div_rsp.quot[12:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
            cell_cfg_reg   <= CELL_SIZE_RESET;
            max_cfg_reg    <= MAX_SLOPE_RESET;
            obst_cfg_reg   <= OBST_SLOPE_RESET;
            height_cfg_reg <= VEH_HEIGHT_RESET;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CELL_SIZE:  cell_cfg_reg   <= cfg_wdata[9:0];
                    CFG_MAX_SLOPE:  max_cfg_reg    <= cfg_wdata;
                    CFG_OBST_SLOPE: obst_cfg_reg   <= cfg_wdata;
                    CFG_VEH_HEIGHT: height_cfg_reg <= cfg_wdata[12:0];
                    default: begin
                    end
                endcase
            end
        end
        cell_reg      <= cell_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        uy_reg        <= uy_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        mean_reg      <= mean_next;
        hits_reg      <= hits_next;
        neg_reg       <= neg_next;
        nb_reg        <= nb_next;
        best_reg      <= best_next;
        res_acc_reg   <= res_acc_next;
        res_elev_reg  <= res_elev_next;
        res_hits_reg  <= res_hits_next;
        res_slope_reg <= res_slope_next;
        res_int_reg   <= res_int_next;
        if (out_load) begin
            m_acc_reg   <= res_acc_reg;
            m_elev_reg  <= res_elev_reg;
            m_hits_reg  <= res_hits_reg;
            m_slope_reg <= res_slope_reg;
            m_int_reg   <= res_int_reg;
        end
    end

    egsm_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    egsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    egsm_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cord_req),
        .rsp     (cord_rsp)
    );

    assign s_ready             = (state_reg == S_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_accepted          = m_acc_reg;
    assign m_cell_elevation_mm = m_elev_reg;
    assign m_cell_hits         = m_hits_reg;
    assign m_slope_cdeg        = m_slope_reg;
    assign m_intensity_mm      = m_int_reg;
endmodule
